FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/crlm_pkg.sv
package crlm_pkg;

    localparam int LINE_CAPACITY     = 64;
    localparam int MAX_COMMAND_CHARS = 16;

    localparam int LC_W  = $clog2(LINE_CAPACITY);
    localparam int CMP_W = LC_W + 1;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 64;
    localparam int CLEN_W   = 5;
    localparam int RETRY_W  = 8;
    localparam int CIDX_W   = 2;
    localparam int ERR_TEXT_LEN = 20;
    localparam int RES_LEN      = 4;

    localparam logic [VALUE_W-1:0] MAG_LIMIT_DIV10 = 32'd214748364;
    localparam logic [VALUE_W-1:0] POS_MAX         = 32'h7FFF_FFFF;
    localparam logic [3:0]         DIGIT_MAX_LAST  = 4'd8;

    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_BYTE   = 2'd1,
        FUNC_RD_ERR = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DEV_ERR   = 2'd2,
        ST_GAVE_UP   = 2'd3
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_CMD_FIRST   = 2'd0,
        CFG_CMD_SECOND  = 2'd1,
        CFG_CMD_LENGTH  = 2'd2,
        CFG_RETRY_LIMIT = 2'd3
    } cfg_index_t;

    // "RES " then the command bytes
    function automatic logic [BYTE_W-1:0] prefix_char(
        input logic [CMP_W-1:0] k,
        input logic [CMD_W-1:0] first,
        input logic [CMD_W-1:0] second
    );
        logic [CMP_W-1:0] c;
        logic [BYTE_W-1:0] ch;
        c = k - CMP_W'(RES_LEN);
        case (k[1:0])
            2'd0:    ch = 8'h52;
            2'd1:    ch = 8'h45;
            2'd2:    ch = 8'h53;
            default: ch = 8'h20;
        endcase
        if (k >= CMP_W'(RES_LEN)) begin
            if (c < CMP_W'(8)) begin
                ch = first[{c[2:0], 3'b000} +: BYTE_W];
            end else begin
                ch = second[{c[2:0], 3'b000} +: BYTE_W];
            end
        end
        return ch;
    endfunction

    // "ERR Unknown command."
    function automatic logic [BYTE_W-1:0] err_char(input logic [4:0] k);
        logic [BYTE_W-1:0] ch;
        case (k)
            5'd0:    ch = 8'h45;
            5'd1:    ch = 8'h52;
            5'd2:    ch = 8'h52;
            5'd3:    ch = 8'h20;
            5'd4:    ch = 8'h55;
            5'd5:    ch = 8'h6E;
            5'd6:    ch = 8'h6B;
            5'd7:    ch = 8'h6E;
            5'd8:    ch = 8'h6F;
            5'd9:    ch = 8'h77;
            5'd10:   ch = 8'h6E;
            5'd11:   ch = 8'h20;
            5'd12:   ch = 8'h63;
            5'd13:   ch = 8'h6F;
            5'd14:   ch = 8'h6D;
            5'd15:   ch = 8'h6D;
            5'd16:   ch = 8'h61;
            5'd17:   ch = 8'h6E;
            5'd18:   ch = 8'h64;
            5'd19:   ch = 8'h2E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/command_response_line_matcher.sv
// Matches response lines from a byte stream against "RES <command>" and returns
// the signed decimal number that follows, or a malformed, device error or
// gave-up status. Items are a start (tuser 0), a received byte (tuser 1) or a
// read error (tuser 2); a line ends at a newline byte. One item is taken per
// clock cycle: it lands in an input register and is evaluated from there
// into the result register once that register is free or m_tready is high.
// The only thing that slows the input is the result register: while a
// result waits for m_tready, one more item is taken and then s_tready drops.
// Configuration writes are always accepted and must be made while no item
// is in flight.
module command_response_line_matcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [crlm_pkg::BYTE_W-1:0]      s_tdata,   // rx_byte
    input  logic [1:0]                       s_tuser,   // func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [crlm_pkg::VALUE_W-1:0]     m_tdata,   // value
    output logic [1:0]                       m_tuser,   // status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crlm_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [crlm_pkg::CMD_W-1:0]       cfg_data
);
    import crlm_pkg::*;

    logic [CMD_W-1:0]   cmd_first_reg, cmd_second_reg;
    logic [CLEN_W-1:0]  cmd_len_reg;
    logic [RETRY_W-1:0] retry_limit_reg;

    logic               in_valid_reg;
    logic [1:0]         in_func_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               advance;

    logic [LC_W-1:0]    line_count_reg, line_count_next;
    logic               prefix_ok_reg, prefix_ok_next;
    logic               err_ok_reg, err_ok_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               digit_seen_reg, digit_seen_next;
    logic               num_bad_reg, num_bad_next;
    logic [RETRY_W-1:0] retries_reg, retries_next;
    logic               waiting_reg, waiting_next;

    logic               m_valid_reg;
    logic [VALUE_W-1:0] m_value_reg;
    status_t            m_status_reg;

    logic               res_valid;
    status_t            res_status;
    logic [VALUE_W-1:0] res_value;

    logic [CLEN_W-1:0]  clen;
    logic [CMP_W-1:0]   plen, k;
    logic [3:0]         digit;
    logic               is_digit;
    logic [VALUE_W-1:0] acc_x10;
    logic [RETRY_W-1:0] retry_dec;
    logic               pre_hit, err_hit, num_bad_end;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_first_reg   <= '0;
            cmd_second_reg  <= '0;
            cmd_len_reg     <= CLEN_W'(1);
            retry_limit_reg <= RETRY_W'(10);
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_CMD_FIRST:   cmd_first_reg   <= cfg_data;
                CFG_CMD_SECOND:  cmd_second_reg  <= cfg_data;
                CFG_CMD_LENGTH:  cmd_len_reg     <= cfg_data[CLEN_W-1:0];
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_comb begin
        if (cmd_len_reg == '0) begin
            clen = CLEN_W'(1);
        end else if (cmd_len_reg > CLEN_W'(MAX_COMMAND_CHARS)) begin
            clen = CLEN_W'(MAX_COMMAND_CHARS);
        end else begin
            clen = cmd_len_reg;
        end
    end

    assign plen      = CMP_W'(RES_LEN) + CMP_W'(clen);
    assign k         = CMP_W'(line_count_reg);
    assign is_digit  = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign digit     = 4'(in_byte_reg - CH_ZERO);
    assign acc_x10   = (acc_reg << 3) + (acc_reg << 1);
    assign retry_dec = (retries_reg == '0) ? '0 : retries_reg - RETRY_W'(1);

    assign pre_hit     = prefix_ok_reg && (k >= plen);
    assign err_hit     = err_ok_reg && (k >= CMP_W'(ERR_TEXT_LEN));
    assign num_bad_end = num_bad_reg || !digit_seen_reg || (k <= plen + CMP_W'(1))
                         || (!neg_reg && (acc_reg > POS_MAX));

    always_comb begin
        line_count_next = line_count_reg;
        prefix_ok_next  = prefix_ok_reg;
        err_ok_next     = err_ok_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        digit_seen_next = digit_seen_reg;
        num_bad_next    = num_bad_reg;
        retries_next    = retries_reg;
        waiting_next    = waiting_reg;
        res_valid       = 1'b0;
        res_status      = ST_GAVE_UP;
        res_value       = '1;

        if (advance) begin
            case (func_t'(in_func_reg))
                FUNC_START: begin
                    line_count_next = '0;
                    prefix_ok_next  = 1'b1;
                    err_ok_next     = 1'b1;
                    acc_next        = '0;
                    neg_next        = 1'b0;
                    digit_seen_next = 1'b0;
                    num_bad_next    = 1'b0;
                    retries_next    = retry_limit_reg;
                    if (retry_limit_reg == '0) begin
                        waiting_next = 1'b0;
                        res_valid    = 1'b1;
                    end else begin
                        waiting_next = 1'b1;
                    end
                end
                FUNC_BYTE: begin
                    if (waiting_reg && in_byte_reg == CH_NL) begin
                        line_count_next = '0;
                        prefix_ok_next  = 1'b1;
                        err_ok_next     = 1'b1;
                        acc_next        = '0;
                        neg_next        = 1'b0;
                        digit_seen_next = 1'b0;
                        num_bad_next    = 1'b0;
                        if (pre_hit) begin
                            waiting_next = 1'b0;
                            res_valid    = 1'b1;
                            if (num_bad_end) begin
                                res_status = ST_MALFORMED;
                            end else begin
                                res_status = ST_OK;
                                res_value  = neg_reg ? (VALUE_W'(0) - acc_reg) : acc_reg;
                            end
                        end else if (err_hit) begin
                            waiting_next = 1'b0;
                            res_valid    = 1'b1;
                            res_status   = ST_DEV_ERR;
                        end else begin
                            retries_next = retry_dec;
                            if (retry_dec == '0) begin
                                waiting_next = 1'b0;
                                res_valid    = 1'b1;
                            end
                        end
                    end else if (waiting_reg && k < CMP_W'(LINE_CAPACITY - 1)) begin
                        if (k < plen && in_byte_reg != prefix_char(k, cmd_first_reg,
                                                                  cmd_second_reg)) begin
                            prefix_ok_next = 1'b0;
                        end
                        if (k < CMP_W'(ERR_TEXT_LEN) && in_byte_reg != err_char(k[4:0])) begin
                            err_ok_next = 1'b0;
                        end
                        if (k > plen && !num_bad_reg) begin
                            if (k == plen + CMP_W'(1)
                                && (in_byte_reg == CH_MINUS || in_byte_reg == CH_PLUS)) begin
                                neg_next = (in_byte_reg == CH_MINUS);
                            end else if (is_digit) begin
                                if (acc_reg > MAG_LIMIT_DIV10
                                    || (acc_reg == MAG_LIMIT_DIV10 && digit > DIGIT_MAX_LAST)) begin
                                    num_bad_next = 1'b1;
                                end else begin
                                    acc_next        = acc_x10 + VALUE_W'(digit);
                                    digit_seen_next = 1'b1;
                                end
                            end else begin
                                num_bad_next = 1'b1;
                            end
                        end
                        line_count_next = line_count_reg + LC_W'(1);
                    end
                end
                FUNC_RD_ERR: begin
                    if (waiting_reg) begin
                        retries_next = retry_dec;
                        if (retry_dec == '0) begin
                            waiting_next = 1'b0;
                            res_valid    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= '0;
            prefix_ok_reg  <= 1'b1;
            err_ok_reg     <= 1'b1;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            digit_seen_reg <= 1'b0;
            num_bad_reg    <= 1'b0;
            retries_reg    <= '0;
            waiting_reg    <= 1'b0;
        end else begin
            line_count_reg <= line_count_next;
            prefix_ok_reg  <= prefix_ok_next;
            err_ok_reg     <= err_ok_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            digit_seen_reg <= digit_seen_next;
            num_bad_reg    <= num_bad_next;
            retries_reg    <= retries_next;
            waiting_reg    <= waiting_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_status_reg <= res_status;
            m_value_reg  <= res_value;
        end
    end

endmodule

FILE: rtl/crlm_checker.sv
`include "assert_macros.svh"

module crlm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [crlm_pkg::VALUE_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);
    import crlm_pkg::*;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // any status but ok carries minus one
    `ASSERT_IMPL(a_fail_value, aclk, aresetn, m_tvalid && m_tuser != ST_OK,
        m_tdata == '1)

    // input only stalls behind a waiting result
    `ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

endmodule

bind command_response_line_matcher crlm_checker u_crlm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
